// File: hw/rtl/iou_parent_box_match_defines.svh
// ----------------------------------------------------------------------------
// iou_parent_box_match_defines.svh
// Assertion macros shared by the parent box match RTL.
// ----------------------------------------------------------------------------
`ifndef IOU_PARENT_BOX_MATCH_DEFINES_SVH
`define IOU_PARENT_BOX_MATCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// Types and constants of the parent box match block.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

    localparam int MAX_PARENTS = 32;
    localparam int COORD_BITS  = 13;
    localparam int CLASS_W     = 8;
    localparam int ID_W        = 64;
    localparam int CMD_W       = 2;

    localparam int IDX_W  = (MAX_PARENTS > 1) ? $clog2(MAX_PARENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_PARENTS + 1);
    localparam int SPAN_W = COORD_BITS + 1;
    // intersection, areas and union all fit here
    localparam int MUL_W  = 2 * SPAN_W;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MATCH = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PARENT_CLASS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHILD_CLASS  = 1'b1;

    localparam logic [CLASS_W-1:0] PARENT_CLASS_RST = 8'd1;
    localparam logic [CLASS_W-1:0] CHILD_CLASS_RST  = 8'd4;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic [CLASS_W-1:0]    class_id;
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [COORD_BITS-1:0] box_width;
        logic [COORD_BITS-1:0] box_height;
        logic [ID_W-1:0]       box_id;
    } t_item;

    typedef struct packed {
        logic            matched;
        logic [ID_W-1:0] new_object_id;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/iou_parent_box_match.sv
// ----------------------------------------------------------------------------
// iou_parent_box_match
// Parent table with max-IoU association of child boxes to parents.
// ----------------------------------------------------------------------------
// Clear and load transactions finish in the accept cycle and never raise busy.
// A match of the child class holds busy through its scan of the stored
// parents (none on an empty table) and its result. One shared multiplier
// forms the child area, then per parent the intersection, the parent area
// and two cross products of the ratio compare, one product per cycle, plus
// a table read. The first parent with overlap skips the ratio compare.
// Parents with no overlap skip the union and the ratio compare. The result
// shows on o_result for the single cycle o_strobe is high; the receiver
// cannot stall it.
`default_nettype none

`include "iou_parent_box_match_defines.svh"

module iou_parent_box_match (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire pbm_pkg::t_item                i_item,
    output logic                               o_strobe,
    output pbm_pkg::t_result                   o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [pbm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pbm_pkg::CLASS_W-1:0]   i_cfg_data
);
    import pbm_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] width;
        logic [COORD_BITS-1:0] height;
        logic [ID_W-1:0]       ident;
    } t_parent;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_AREA  = 4'd1;
    localparam logic [3:0] ST_FETCH = 4'd2;
    localparam logic [3:0] ST_OVL   = 4'd3;
    localparam logic [3:0] ST_INT   = 4'd4;
    localparam logic [3:0] ST_PAR   = 4'd5;
    localparam logic [3:0] ST_UNI   = 4'd6;
    localparam logic [3:0] ST_X1    = 4'd7;
    localparam logic [3:0] ST_X2    = 4'd8;
    localparam logic [3:0] ST_CMP   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    function automatic logic [SPAN_W-1:0] span_overlap(
        input logic [COORD_BITS-1:0] s0,
        input logic [COORD_BITS-1:0] l0,
        input logic [COORD_BITS-1:0] s1,
        input logic [COORD_BITS-1:0] l1
    );
        logic [SPAN_W-1:0] lo;
        logic [SPAN_W-1:0] hi;
        logic [SPAN_W-1:0] e0;
        logic [SPAN_W-1:0] e1;
        lo = (s0 > s1) ? SPAN_W'(s0) : SPAN_W'(s1);
        e0 = SPAN_W'(s0) + SPAN_W'(l0);
        e1 = SPAN_W'(s1) + SPAN_W'(l1);
        hi = (e0 < e1) ? e0 : e1;
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

    t_parent r_mem [MAX_PARENTS];
    t_parent r_rd;

    logic [3:0]         r_state, n_state;
    logic [CLASS_W-1:0] r_parent_class;
    logic [CLASS_W-1:0] r_child_class;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_k, n_k;
    logic               r_found, n_found;
    t_item              r_box;
    logic [SPAN_W-1:0]  r_iw, r_ih;
    logic [MUL_W-1:0]   r_area;
    logic [MUL_W-1:0]   r_inter;
    logic [MUL_W-1:0]   r_uni;
    logic [MUL_W-1:0]   r_best_i, r_best_u;
    logic [ID_W-1:0]    r_best_id;
    logic [PROD_W-1:0]  r_lhs;

    logic              accept;
    logic              do_load;
    logic              start_match;
    logic              last_parent;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [MUL_W-1:0]  uni_now;
    logic              take_now;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign do_load  = accept && (i_item.command == CMD_LOAD)
                      && (i_item.class_id == r_parent_class)
                      && (r_count < CNT_W'(MAX_PARENTS));
    assign start_match = accept && (i_item.command == CMD_MATCH)
                         && (i_item.class_id == r_child_class);
    assign last_parent = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    assign uni_now  = prod[MUL_W-1:0] + r_area - r_inter;

    pbm_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            ST_AREA: begin
                mul_a = MUL_W'(r_box.box_width);
                mul_b = MUL_W'(r_box.box_height);
            end
            ST_INT: begin
                mul_a = MUL_W'(r_iw);
                mul_b = MUL_W'(r_ih);
            end
            ST_PAR: begin
                mul_a = MUL_W'(r_rd.width);
                mul_b = MUL_W'(r_rd.height);
            end
            ST_X1: begin
                mul_a = r_inter;
                mul_b = r_best_u;
            end
            ST_X2: begin
                mul_a = r_best_i;
                mul_b = r_uni;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_found  = r_found;
        take_now = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start_match) begin
                    n_state = ST_AREA;
                    n_k     = '0;
                    n_found = 1'b0;
                end
            end
            ST_AREA:  n_state = (r_count == '0) ? ST_DONE : ST_OVL;
            ST_FETCH: n_state = ST_OVL;
            ST_OVL:   n_state = ST_INT;
            ST_INT:   n_state = ST_PAR;
            ST_PAR: begin
                // no overlap: this parent cannot match
                if (prod == '0) begin
                    n_state = last_parent ? ST_DONE : ST_FETCH;
                    n_k     = last_parent ? r_k : r_k + IDX_W'(1);
                end else begin
                    n_state = ST_UNI;
                end
            end
            ST_UNI: begin
                if (!r_found) begin
                    take_now = 1'b1;
                    n_found  = 1'b1;
                    n_state  = last_parent ? ST_DONE : ST_FETCH;
                    n_k      = last_parent ? r_k : r_k + IDX_W'(1);
                end else begin
                    n_state = ST_X1;
                end
            end
            ST_X1: n_state = ST_X2;
            ST_X2: n_state = ST_CMP;
            ST_CMP: begin
                n_state = last_parent ? ST_DONE : ST_FETCH;
                n_k     = last_parent ? r_k : r_k + IDX_W'(1);
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_parent_class <= PARENT_CLASS_RST;
            r_child_class  <= CHILD_CLASS_RST;
            r_count        <= '0;
            r_k            <= '0;
            r_found        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_found <= n_found;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PARENT_CLASS: r_parent_class <= i_cfg_data;
                    REG_CHILD_CLASS:  r_child_class  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && (i_item.command == CMD_CLEAR)) begin
                r_count <= '0;
            end else if (do_load) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // table and datapath registers
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_mem[r_count[IDX_W-1:0]] <= '{left:   i_item.box_left,
                                           top:    i_item.box_top,
                                           width:  i_item.box_width,
                                           height: i_item.box_height,
                                           ident:  i_item.box_id};
        end
        r_rd <= r_mem[r_k];

        if (accept) begin
            r_box     <= i_item;
            r_best_id <= i_item.box_id;
        end
        if (r_state == ST_OVL) begin
            r_iw <= span_overlap(r_rd.left, r_rd.width, r_box.box_left, r_box.box_width);
            r_ih <= span_overlap(r_rd.top, r_rd.height, r_box.box_top, r_box.box_height);
            // product of the child area lands here on the first parent only
            if (r_k == '0) begin
                r_area <= prod[MUL_W-1:0];
            end
        end
        if (r_state == ST_PAR) begin
            r_inter <= prod[MUL_W-1:0];
        end
        if (r_state == ST_UNI) begin
            r_uni <= uni_now;
        end
        if (take_now) begin
            r_best_i  <= r_inter;
            r_best_u  <= uni_now;
            r_best_id <= r_rd.ident;
        end
        if (r_state == ST_X2) begin
            r_lhs <= prod;
        end
        // strict greater keeps the earlier parent on a tie
        if ((r_state == ST_CMP) && (r_lhs > prod)) begin
            r_best_i  <= r_inter;
            r_best_u  <= r_uni;
            r_best_id <= r_rd.ident;
        end
    end

    assign o_strobe               = (r_state == ST_DONE);
    assign o_result.matched       = r_found;
    assign o_result.new_object_id = r_best_id;

    `PBM_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(MAX_PARENTS), "parent count overflow")
    `PBM_ASSERT_NOW(a_scan_in_table, r_state == ST_OVL, CNT_W'(r_k) < r_count, "scan past end")
    `PBM_ASSERT_NEXT(a_strobe_ends, o_strobe, !busy && !o_strobe, "result strobe not single")
    `PBM_ASSERT_NEXT(a_match_starts, start_match, busy && (r_state == ST_AREA), "match not started")

endmodule

`default_nettype wire

// File: hw/rtl/pbm_mul.sv
// ----------------------------------------------------------------------------
// pbm_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_mul (
    input  wire logic                       i_clk,
    input  wire logic [pbm_pkg::MUL_W-1:0]  i_a,
    input  wire logic [pbm_pkg::MUL_W-1:0]  i_b,
    output logic      [pbm_pkg::PROD_W-1:0] o_prod
);
    import pbm_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
